@@ hdl/ics_pkg.sv @@
package ics_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SRC  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DST  = 2'd2;

	localparam logic [15:0] UDP_PROTOCOL = 16'd17;

	typedef struct packed {
		logic [15:0] data_word;
		logic        two_bytes_valid;
		logic        last_word;
	} in_item_t;

	typedef struct packed {
		logic [15:0] checksum_value;
		logic [15:0] byte_length;
	} out_item_t;

	function automatic logic [15:0] ones_fold(input logic [19:0] x);
		logic [16:0] f1;
		logic [16:0] f2;
		f1 = {1'b0, x[15:0]} + 17'(x[19:16]);
		f2 = {1'b0, f1[15:0]} + 17'(f1[16]);
		return f2[15:0];
	endfunction

endpackage

@@ hdl/internet_checksum_stream_core.sv @@
// Streaming Internet checksum with optional UDP pseudo-header.
// Input channel: in_valid / in_stall carry one 16-bit packet word per
// transaction, with a two-byte flag and a last-word flag. Output channel:
// out_valid / out_stall carry one result (checksum and byte count) for each
// packet, produced by the transaction that carries the last word.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 mode,
// 1 source address, 2 destination address); the user writes only while
// no packet is in flight; the block does not enforce this. A last word
// passes the input register and then the result register to the output.
// Throughput: one word per cycle unless a final word waits (see Stall); the
// one's complement accumulate is a single 16-bit adder with end-around carry,
// closed with the pseudo-header adder. Stall: while a result waits, non-final
// words keep being accepted; a final word is held in the input register and
// in_stall rises only while it waits for the result register.
// Reset: clears the running sum, the byte count, the configuration and all
// valid flags.
module internet_checksum_stream_core #(
	parameter int unsigned LENGTH_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  ics_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output ics_pkg::out_item_t                 out_data,
	input  logic                               cfg_we,
	input  logic [ics_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ics_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic                    mode_q;
	logic [31:0]             src_q;
	logic [31:0]             dst_q;

	logic                    valid_s1;
	ics_pkg::in_item_t       item_s1;
	logic [15:0]             sum_q;
	logic [LENGTH_WIDTH-1:0] bytes_q;

	logic                    out_valid_q;
	ics_pkg::out_item_t      out_q;

	logic                    out_free;
	logic                    s1_go;
	logic                    s1_free;

	logic [15:0]             word_m;
	logic [16:0]             sum_add;
	logic [16:0]             sum_fold;
	logic [15:0]             new_sum;
	logic [LENGTH_WIDTH-1:0] new_len;
	logic [15:0]             len16;
	logic [18:0]             pseudo_raw;
	logic [15:0]             pseudo_sum;
	logic [19:0]             total;
	logic [15:0]             closed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			src_q  <= '0;
			dst_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ics_pkg::CFG_MODE: mode_q <= cfg_wdata[0];
				ics_pkg::CFG_SRC:  src_q  <= cfg_wdata[31:0];
				ics_pkg::CFG_DST:  dst_q  <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign s1_go    = valid_s1 && (!item_s1.last_word || out_free);
	assign s1_free  = !valid_s1 || s1_go;
	assign in_stall = !s1_free;

	always_comb begin
		word_m   = item_s1.two_bytes_valid ? item_s1.data_word
			: {item_s1.data_word[15:8], 8'h00};
		sum_add  = {1'b0, sum_q} + {1'b0, word_m};
		sum_fold = {1'b0, sum_add[15:0]} + 17'(sum_add[16]);
		new_sum  = sum_fold[15:0];
		new_len  = bytes_q + (item_s1.two_bytes_valid ? LENGTH_WIDTH'(2) : LENGTH_WIDTH'(1));
		len16    = 16'(new_len);
		pseudo_raw = 19'(src_q[31:16]) + 19'(src_q[15:0]) + 19'(dst_q[31:16])
			+ 19'(dst_q[15:0]) + 19'(ics_pkg::UDP_PROTOCOL);
		pseudo_sum = ics_pkg::ones_fold(20'(pseudo_raw));
		total    = 20'(new_sum) + 20'(pseudo_sum) + 20'(len16);
		closed   = mode_q ? ics_pkg::ones_fold(total) : new_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			bytes_q <= '0;
		end else if (s1_go) begin
			if (item_s1.last_word) begin
				sum_q   <= '0;
				bytes_q <= '0;
			end else begin
				sum_q   <= new_sum;
				bytes_q <= new_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_go && item_s1.last_word;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && item_s1.last_word) begin
			out_q.checksum_value <= ~closed;
			out_q.byte_length    <= len16;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_stall_only_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && item_s1.last_word && out_valid_q && out_stall))
		else $error("input stalled without a waiting final word");

	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && item_s1.last_word) |=> (sum_q == '0 && bytes_q == '0))
		else $error("running state not cleared after final word");

	a_result_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_go && item_s1.last_word))
		else $error("result raised without a final word");

endmodule

@@ tb/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LEN_W       = 16;
	localparam int unsigned LEN_MASK    = (32'd1 << LEN_W) - 1;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned WATCHDOG    = 2000;
	localparam int unsigned DRAIN_GAP   = 4;

	class checksum_scoreboard;
		logic        mode;
		logic [31:0] src_ip;
		logic [31:0] dst_addr;
		logic [15:0] acc;
		int unsigned byte_count;
		ics_pkg::out_item_t pending_results[$];
		int unsigned mismatches;

		function new();
			mode = 1'b0;
			src_ip = '0;
			dst_addr = '0;
			acc = '0;
			byte_count = 0;
			mismatches = 0;
		endfunction

		static function logic [15:0] fold_add(logic [15:0] a, logic [15:0] b);
			logic [16:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[15:0] + 16'(s[16]);
		endfunction

		function void set_register(logic [ics_pkg::CFG_INDEX_W-1:0] idx,
			logic [ics_pkg::CFG_DATA_W-1:0] value);
			case (idx)
				ics_pkg::CFG_MODE: mode = value[0];
				ics_pkg::CFG_SRC:  src_ip = value;
				ics_pkg::CFG_DST:  dst_addr = value;
				default: ;
			endcase
		endfunction

		function void note_word(ics_pkg::in_item_t w);
			logic [15:0] word;
			logic [15:0] total;
			ics_pkg::out_item_t want;
			word = w.data_word;
			if (!w.two_bytes_valid)
				word[7:0] = 8'h00;
			acc = fold_add(acc, word);
			byte_count = (byte_count + (w.two_bytes_valid ? 2 : 1)) & LEN_MASK;
			if (w.last_word) begin
				total = acc;
				if (mode) begin
					total = fold_add(total, src_ip[31:16]);
					total = fold_add(total, src_ip[15:0]);
					total = fold_add(total, dst_addr[31:16]);
					total = fold_add(total, dst_addr[15:0]);
					total = fold_add(total, ics_pkg::UDP_PROTOCOL);
					total = fold_add(total, 16'(byte_count));
				end
				want.checksum_value = ~total;
				want.byte_length = 16'(byte_count);
				pending_results.push_back(want);
				acc = '0;
				byte_count = 0;
			end
		endfunction

		function void report(string what, logic [15:0] want, logic [15:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %h actual %h", $realtime, what, want, got);
		endfunction

		function void check_result(ics_pkg::out_item_t got);
			ics_pkg::out_item_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result checksum %h length %h", $realtime,
						got.checksum_value, got.byte_length);
				return;
			end
			want = pending_results.pop_front();
			if (got.checksum_value !== want.checksum_value)
				report("checksum_value", want.checksum_value, got.checksum_value);
			if (got.byte_length !== want.byte_length)
				report("byte_length", want.byte_length, got.byte_length);
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	ics_pkg::in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	ics_pkg::out_item_t out_data;
	logic      cfg_we;
	logic [ics_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [ics_pkg::CFG_DATA_W-1:0]  cfg_wdata;

	bit calm;
	bit hold_off;
	int unsigned quiet_cycles;

	checksum_scoreboard sb = new();

	internet_checksum_stream_core #(
		.LENGTH_WIDTH(LEN_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_word(in_data);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// receiver: random stalls, a quiet stretch, and one long hold-off
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 29);
			end
		end
	end

	function automatic ics_pkg::in_item_t make_word(logic [15:0] data, logic two, logic last);
		ics_pkg::in_item_t w;
		w.data_word = data;
		w.two_bytes_valid = two;
		w.last_word = last;
		return w;
	endfunction

	function automatic ics_pkg::in_item_t random_word(logic last, int unsigned one_byte_pct);
		ics_pkg::in_item_t w;
		case ($urandom_range(9))
			0: w.data_word = 16'h0000;
			1: w.data_word = 16'hFFFF;
			default: w.data_word = 16'($urandom);
		endcase
		w.two_bytes_valid = $urandom_range(99) >= one_byte_pct;
		w.last_word = last;
		return w;
	endfunction

	function automatic logic [31:0] pick_address();
		case ($urandom_range(3))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic offer_word(input ics_pkg::in_item_t w);
		if (!calm) begin
			while ($urandom_range(99) < 29) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_packet(input int unsigned words, input int unsigned one_byte_pct);
		for (int unsigned i = 0; i < words; i++)
			offer_word(random_word(i == words - 1, one_byte_pct));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ics_pkg::CFG_INDEX_W-1:0] idx,
		input logic [ics_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(idx, value);
		@(posedge clk);
	endtask

	task automatic configure(input logic mode, input logic [31:0] src, input logic [31:0] dst);
		wait_idle();
		write_reg(ics_pkg::CFG_MODE, {31'd0, mode});
		write_reg(ics_pkg::CFG_SRC, src);
		write_reg(ics_pkg::CFG_DST, dst);
	endtask

	initial begin
		int unsigned words_sent;
		int unsigned budget;
		int unsigned len;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= ics_pkg::CFG_MODE;
		cfg_wdata <= '0;
		calm = 1'b0;
		hold_off = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain mode straight out of reset
		offer_word(make_word(16'hFFFF, 1'b1, 1'b1));
		offer_word(make_word(16'h0000, 1'b1, 1'b1));
		offer_word(make_word(16'hABCD, 1'b0, 1'b0));
		offer_word(make_word(16'h1234, 1'b1, 1'b1));
		offer_word(make_word(16'hFFFF, 1'b0, 1'b1));
		offer_word(make_word(16'hFFFF, 1'b1, 1'b0));
		offer_word(make_word(16'hFFFF, 1'b1, 1'b0));
		offer_word(make_word(16'h0001, 1'b1, 1'b1));

		configure(1'b1, 32'h0000_0000, 32'h0000_0000);
		offer_word(make_word(16'hFFEC, 1'b1, 1'b1));
		offer_word(make_word(16'h00FF, 1'b0, 1'b1));

		configure(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer_word(make_word(16'hFFFF, 1'b1, 1'b0));
		offer_word(make_word(16'h5A5A, 1'b0, 1'b1));

		configure(1'b1, 32'h8000_0000, 32'h0000_FFFF);
		offer_word(make_word(16'h8000, 1'b1, 1'b0));
		offer_word(make_word(16'h7FFF, 1'b1, 1'b1));

		configure(1'b0, 32'h8000_0000, 32'hFFFF_FFFF);
		offer_word(make_word(16'h0000, 1'b0, 1'b1));

		for (int unsigned phase = 0; phase < 14; phase++) begin
			configure(phase[0], pick_address(), pick_address());
			calm = (phase == 3);
			budget = (phase == 3) ? 120 : 45;
			if (phase == 6)
				hold_off = 1'b1;
			words_sent = 0;
			while (words_sent < budget) begin
				if (phase == 6)
					len = $urandom_range(1, 2);
				else if ($urandom_range(9) == 0)
					len = $urandom_range(9, 40);
				else
					len = $urandom_range(1, 8);
				send_packet(len, 15);
				words_sent += len;
			end
		end
		calm = 1'b0;

		wait_idle();
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
